>>> design/sfir_pkg.sv
// Shared types and constants for the stereo FIR filter.
`default_nettype none

package sfir_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int FRAC_BITS     = 8;
  localparam int CHANNELS      = 2;
  localparam int CMD_BITS      = 2;
  localparam int COEF_IDX_BITS = 5;
  localparam int TAPS_DEFAULT  = 32;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_COEF  = 2'd1,
    CMD_CLEAR = 2'd2
  } sfir_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } sfir_state_t;

  typedef struct packed {
    logic push_wr;
    logic coef_wr;
    logic hist_clr;
    logic issue;
    logic out_load;
  } sfir_ctl_t;

  typedef struct packed {
    logic last_tap;
    logic busy;
  } sfir_sts_t;

endpackage

`default_nettype wire

>>> design/sfir_if.sv
// Valid/ready channel interfaces for sample commands and filtered results.
`default_nettype none

interface sfir_in_if import sfir_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CMD_BITS-1:0]         cmd;
  logic [SAMPLE_BITS-1:0]      left_sample;
  logic [SAMPLE_BITS-1:0]      right_sample;
  logic [COEF_IDX_BITS-1:0]    coef_index;
  logic signed [COEF_BITS-1:0] coef_value;

  modport source (
    output valid, cmd, left_sample, right_sample, coef_index, coef_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, left_sample, right_sample, coef_index, coef_value,
    output ready
  );
endinterface

interface sfir_out_if import sfir_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_out;
  logic [SAMPLE_BITS-1:0] right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out,
    output ready
  );
endinterface

`default_nettype wire

>>> design/sfir_ctrl.sv
// Sequencer for command decode, tap loop, drain and result hand-off.
`default_nettype none

module sfir_ctrl import sfir_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CMD_BITS-1:0] in_cmd,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sfir_ctl_t                ctl,
  input  wire sfir_sts_t           sts
);

  sfir_state_t state_r, state_nxt;
  logic        out_vld_r, out_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_cmd == CMD_PUSH)) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.last_tap) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.busy) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_PUSH:  ctl.push_wr  = 1'b1;
            CMD_COEF:  ctl.coef_wr  = 1'b1;
            CMD_CLEAR: ctl.hist_clr = 1'b1;
            default:   ;
          endcase
        end
      end
      ST_RUN:   ctl.issue    = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   ctl.out_load = !out_vld_r || out_ready;
      default:  ;
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_valid = out_vld_r;

endmodule

`default_nettype wire

>>> design/sfir_datapath.sv
// History and coefficient memories, MAC pipeline, rounding and saturation.
`default_nettype none

module sfir_datapath import sfir_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sfir_ctl_t                   ctl,
  output sfir_sts_t                        sts,
  input  wire logic [SAMPLE_BITS-1:0]      left_sample,
  input  wire logic [SAMPLE_BITS-1:0]      right_sample,
  input  wire logic [COEF_IDX_BITS-1:0]    coef_index,
  input  wire logic signed [COEF_BITS-1:0] coef_value,
  output logic [SAMPLE_BITS-1:0]           left_out,
  output logic [SAMPLE_BITS-1:0]           right_out
);

  localparam int PW     = $clog2(TAPS);
  localparam int HW     = CHANNELS * SAMPLE_BITS;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + PW;
  localparam int SUM_W  = ACC_W + 2;
  localparam logic signed [SUM_W-1:0] RND    = SUM_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [SUM_W-1:0] MID_SH =
    SUM_W'(1) <<< (SAMPLE_BITS - 1 + FRAC_BITS);

  logic [HW-1:0]        hist_mem [TAPS];
  logic [COEF_BITS-1:0] coef_mem [TAPS];

  logic [TAPS-1:0] hist_vld_r;
  logic [TAPS-1:0] coef_vld_r;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   tap_r, tap_nxt;
  logic            s1_vld_r;
  logic            s2_vld_r;

  logic [HW-1:0]               hist_rd_r;
  logic                        hist_rv_r;
  logic signed [COEF_BITS-1:0] coef_rd_r;
  logic                        coef_rv_r;

  logic signed [PROD_W-1:0]      prod_r  [CHANNELS];
  logic signed [ACC_W-1:0]       acc_r   [CHANNELS];
  logic [SAMPLE_BITS-1:0]        out_smp_r [CHANNELS];
  logic [SAMPLE_BITS-1:0]        smp_in  [CHANNELS];
  logic [HW-1:0]                 hist_wdata;
  logic signed [COEF_BITS-1:0]   coef_op;
  logic signed [SAMPLE_BITS-1:0] hist_op [CHANNELS];
  logic signed [SUM_W-1:0]       fin_sum [CHANNELS];
  logic [SAMPLE_BITS-1:0]        fin_smp [CHANNELS];
  logic                          coef_wr_en;
  logic [PW-1:0]                 cw_addr;

  // centering: flip the MSB of offset binary to get two's complement
  assign smp_in[0] = left_sample;
  assign smp_in[1] = right_sample;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      hist_wdata[c*SAMPLE_BITS +: SAMPLE_BITS] =
        {~smp_in[c][SAMPLE_BITS-1], smp_in[c][SAMPLE_BITS-2:0]};
    end
  end

  assign coef_wr_en = ctl.coef_wr && (32'(coef_index) < TAPS);
  assign cw_addr    = PW'(coef_index);

  always_ff @(posedge clk) begin
    if (ctl.push_wr) hist_mem[wr_ptr_r] <= hist_wdata;
    if (coef_wr_en) coef_mem[cw_addr] <= coef_value;
    hist_rd_r <= hist_mem[rd_ptr_r];
    coef_rd_r <= coef_mem[tap_r];
    hist_rv_r <= hist_vld_r[rd_ptr_r];
    coef_rv_r <= coef_vld_r[tap_r];
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (ctl.hist_clr) begin
      wr_ptr_nxt = '0;
    end else if (ctl.out_load) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(TAPS - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    tap_nxt    = tap_r;
    if (ctl.push_wr) begin
      rd_ptr_nxt = wr_ptr_r;
      tap_nxt    = '0;
    end else if (ctl.issue) begin
      rd_ptr_nxt = (rd_ptr_r == '0) ? PW'(TAPS - 1) : rd_ptr_r - 1'b1;
      if (!sts.last_tap) tap_nxt = tap_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      coef_vld_r <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      tap_r      <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
    end else begin
      if (ctl.hist_clr) begin
        hist_vld_r <= '0;
      end else if (ctl.push_wr) begin
        hist_vld_r[wr_ptr_r] <= 1'b1;
      end
      if (coef_wr_en) coef_vld_r[cw_addr] <= 1'b1;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      tap_r    <= tap_nxt;
      s1_vld_r <= ctl.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // never-written entries read as zero
  always_comb begin
    coef_op = coef_rv_r ? coef_rd_r : '0;
    for (int c = 0; c < CHANNELS; c++) begin
      hist_op[c] = hist_rv_r ? hist_rd_r[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod_r[c] <= coef_op * hist_op[c];
      if (ctl.push_wr) begin
        acc_r[c] <= '0;
      end else if (s2_vld_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

  // truncate toward zero, re-add midpoint, saturate
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      fin_sum[c] = SUM_W'(acc_r[c]) + (acc_r[c][ACC_W-1] ? RND : '0) + MID_SH;
      if (fin_sum[c][SUM_W-1]) begin
        fin_smp[c] = '0;
      end else if (|fin_sum[c][SUM_W-2:FRAC_BITS+SAMPLE_BITS]) begin
        fin_smp[c] = '1;
      end else begin
        fin_smp[c] = fin_sum[c][FRAC_BITS +: SAMPLE_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      for (int c = 0; c < CHANNELS; c++) out_smp_r[c] <= fin_smp[c];
    end
  end

  assign left_out     = out_smp_r[0];
  assign right_out    = out_smp_r[1];
  assign sts.last_tap = (tap_r == PW'(TAPS - 1));
  assign sts.busy     = s1_vld_r || s2_vld_r;

  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> !s1_vld_r && !s2_vld_r)
    else $error("result loaded while MAC pipeline still busy");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wr_ptr_r) < TAPS) && (32'(rd_ptr_r) < TAPS) && (32'(tap_r) < TAPS))
    else $error("pointer out of tap range");

  a_loop_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push_wr |=> (rd_ptr_r == wr_ptr_r) && (tap_r == '0))
    else $error("tap loop does not start at newest sample");

  a_loop_stop: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.issue && sts.last_tap |=> !ctl.issue)
    else $error("tap loop issued past last tap");

endmodule

`default_nettype wire

>>> design/stereo_fir_filter.sv
// Top level of the two-channel offset-binary FIR filter.
//
//   channel   dir   beat contents
//   in_bus    in    cmd, left_sample, right_sample, coef_index, coef_value
//   out_bus   out   left_out, right_out (one beat per push command)
//
// Push: accept, one MAC per tap, MAC pipeline drain, finish; the single
// history/coefficient read port sets the loop length.
// Coefficient write, clear and unused commands give no result beat.
// Reset clears pointers and per-entry valid bits at once; no clearing pass.
// A result beat waits in the output register; only the next finish step stalls.
`default_nettype none

module stereo_fir_filter import sfir_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input wire logic     clk,
  input wire logic     rst_n,
  sfir_in_if.sink      in_bus,
  sfir_out_if.source   out_bus
);

  sfir_ctl_t ctl;
  sfir_sts_t sts;

  sfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_cmd    (in_bus.cmd),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  sfir_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .left_sample  (in_bus.left_sample),
    .right_sample (in_bus.right_sample),
    .coef_index   (in_bus.coef_index),
    .coef_value   (in_bus.coef_value),
    .left_out     (out_bus.left_out),
    .right_out    (out_bus.right_out)
  );

endmodule

`default_nettype wire

>>> dv/tb_stereo_fir_filter.sv
// Self-checking testbench for stereo_fir_filter: random stimulus, in-bench predictor, scoreboard.
`timescale 1ns / 100ps

module tb_stereo_fir_filter import sfir_pkg::*; ();

  localparam int TAPS = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_RANDOM = 550;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam longint MIDPOINT = longint'(1) << (SAMPLE_BITS - 1);
  localparam longint FULL_SCALE = (longint'(1) << SAMPLE_BITS) - 1;

  typedef struct {
    logic [CMD_BITS-1:0]         cmd;
    logic [SAMPLE_BITS-1:0]      left;
    logic [SAMPLE_BITS-1:0]      right;
    logic [COEF_IDX_BITS-1:0]    tap;
    logic signed [COEF_BITS-1:0] coef;
    int                          gap;
    bit                          drain;
  } cmd_item_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } pcm_pair_t;

  logic clk;
  logic rst_n;

  sfir_in_if  in_bus ();
  sfir_out_if out_bus ();

  stereo_fir_filter #(.TAPS(TAPS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always #1 clk = ~clk;

  cmd_item_t pending[$];
  pcm_pair_t filtered_q[$];
  int        n_errors;
  int        cycles;

  // filter state mirror
  int          hist_l[TAPS];
  int          hist_r[TAPS];
  int          coef_tbl[TAPS];
  int unsigned wr_ptr;

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] to_offset_binary(input longint acc);
    longint y;
    y = acc / (longint'(1) << FRAC_BITS) + MIDPOINT;
    if (y < 0) return '0;
    if (y > FULL_SCALE) return '1;
    return y[SAMPLE_BITS-1:0];
  endfunction

  task automatic filter_step(input cmd_item_t it);
    longint    acc_l;
    longint    acc_r;
    int        idx;
    pcm_pair_t res;
    case (it.cmd)
      CMD_COEF: begin
        if (int'(it.tap) < TAPS) coef_tbl[it.tap] = int'(it.coef);
      end
      CMD_CLEAR: begin
        for (int k = 0; k < TAPS; k++) begin
          hist_l[k] = 0;
          hist_r[k] = 0;
        end
        wr_ptr = 0;
      end
      CMD_PUSH: begin
        hist_l[wr_ptr] = int'(longint'(it.left) - MIDPOINT);
        hist_r[wr_ptr] = int'(longint'(it.right) - MIDPOINT);
        acc_l = 0;
        acc_r = 0;
        for (int k = 0; k < TAPS; k++) begin
          idx = (int'(wr_ptr) + TAPS - k) % TAPS;
          acc_l += longint'(coef_tbl[k]) * longint'(hist_l[idx]);
          acc_r += longint'(coef_tbl[k]) * longint'(hist_r[idx]);
        end
        wr_ptr = (wr_ptr + 1) % TAPS;
        res.left  = to_offset_binary(acc_l);
        res.right = to_offset_binary(acc_r);
        filtered_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic cmd_item_t mk_item(input logic [CMD_BITS-1:0] cmd,
                                        input int left, input int right,
                                        input int tap, input int coef);
    cmd_item_t it;
    it.cmd   = cmd;
    it.left  = left[SAMPLE_BITS-1:0];
    it.right = right[SAMPLE_BITS-1:0];
    it.tap   = tap[COEF_IDX_BITS-1:0];
    it.coef  = coef[COEF_BITS-1:0];
    it.gap   = 0;
    it.drain = 1'b0;
    return it;
  endfunction

  function automatic int rand_pcm();
    if ($urandom_range(9) < 7) return $urandom_range(65535);
    return 32768 + $urandom_range(600) - 300;
  endfunction

  function automatic int rand_coef();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(600) - 300;
    if (r < 8) return $urandom_range(65535) - 32768;
    if (r == 8) return 256;
    return -256;
  endfunction

  // driver
  cmd_item_t cur;
  cmd_item_t nxt;
  bit        have_next;
  int        gap_left;

  always @(posedge clk) begin
    logic go;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      have_next = 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) filter_step(cur);
      if (!in_bus.valid || in_bus.ready) begin
        if (!have_next && pending.size() > 0) begin
          nxt = pending.pop_front();
          have_next = 1'b1;
          gap_left = nxt.gap;
        end
        go = have_next;
        if (go && nxt.drain && filtered_q.size() != 0) begin
          go = 1'b0;
        end else if (go && gap_left > 0) begin
          gap_left--;
          go = 1'b0;
        end
        if (go) begin
          in_bus.valid        <= 1'b1;
          in_bus.cmd          <= nxt.cmd;
          in_bus.left_sample  <= nxt.left;
          in_bus.right_sample <= nxt.right;
          in_bus.coef_index   <= nxt.tap;
          in_bus.coef_value   <= nxt.coef;
          cur = nxt;
          have_next = 1'b0;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left;

  always @(posedge clk) begin
    pcm_pair_t want;
    bit        quiet;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (filtered_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat L=%h R=%h",
                                  out_bus.left_out, out_bus.right_out));
        end else begin
          want = filtered_q.pop_front();
          if (out_bus.left_out !== want.left)
            flag_mismatch($sformatf("left_out %h, want %h", out_bus.left_out, want.left));
          if (out_bus.right_out !== want.right)
            flag_mismatch($sformatf("right_out %h, want %h", out_bus.right_out, want.right));
        end
      end
      quiet = (cycles % 3000) < 800;
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (quiet || $urandom_range(99) >= 25) begin
        out_bus.ready <= 1'b1;
      end else begin
        stall_left = rand_gap();
        out_bus.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[stereo_fir_filter] ERROR");
      $finish;
    end
  end

  initial begin
    cmd_item_t it;
    bit        burst;
    int        r;
    clk = 1'b0;
    rst_n = 1'b0;
    n_errors = 0;
    cycles = 0;
    wr_ptr = 0;
    for (int k = 0; k < TAPS; k++) begin
      hist_l[k] = 0;
      hist_r[k] = 0;
      coef_tbl[k] = 0;
    end
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_PUSH;
    in_bus.left_sample = '0;
    in_bus.right_sample = '0;
    in_bus.coef_index = '0;
    in_bus.coef_value = '0;
    out_bus.ready = 1'b0;

    // directed: silence, saturation both ways, negative full scale, edge taps,
    // unused command, clear, truncation toward zero, out-of-range-free tap 31
    pending.push_back(mk_item(CMD_PUSH, 32768, 32768, 0, 0));
    pending.push_back(mk_item(CMD_COEF, 0, 0, 0, 32767));
    pending.push_back(mk_item(CMD_PUSH, 65535, 0, 31, -1));
    pending.push_back(mk_item(CMD_PUSH, 0, 65535, 0, 0));
    pending.push_back(mk_item(CMD_COEF, 65535, 65535, 0, -32768));
    pending.push_back(mk_item(CMD_PUSH, 65535, 0, 0, 0));
    pending.push_back(mk_item(CMD_PUSH, 0, 65535, 0, 0));
    pending.push_back(mk_item(CMD_COEF, 0, 0, 31, -128));
    pending.push_back(mk_item(CMD_UNUSED, 65535, 65535, 31, -1));
    pending.push_back(mk_item(CMD_COEF, 0, 0, 0, 256));
    pending.push_back(mk_item(CMD_PUSH, 40000, 20000, 0, 0));
    it = mk_item(CMD_CLEAR, 12345, 54321, 17, 999);
    it.drain = 1'b1;
    pending.push_back(it);
    pending.push_back(mk_item(CMD_PUSH, 33000, 32000, 0, 0));
    pending.push_back(mk_item(CMD_COEF, 0, 0, 0, 1));
    pending.push_back(mk_item(CMD_PUSH, 32767, 32769, 0, 0));
    pending.push_back(mk_item(CMD_PUSH, 32768 - 300, 32768 + 300, 0, 0));
    pending.push_back(mk_item(CMD_COEF, 0, 0, 1, 128));
    pending.push_back(mk_item(CMD_COEF, 0, 0, 16, -1));
    pending.push_back(mk_item(CMD_PUSH, 1, 65534, 0, 0));
    pending.push_back(mk_item(CMD_PUSH, 65534, 1, 0, 0));
    pending.push_back(mk_item(CMD_UNUSED, 0, 0, 0, 0));
    pending.push_back(mk_item(CMD_PUSH, 32768, 32768, 0, 0));

    burst = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(2) == 0);
      r = $urandom_range(99);
      it = mk_item(CMD_PUSH, rand_pcm(), rand_pcm(), $urandom_range(31), rand_coef());
      if (r >= 62 && r < 82) it.cmd = CMD_COEF;
      else if (r >= 82 && r < 87) it.cmd = CMD_CLEAR;
      else if (r >= 87 && r < 92) it.cmd = CMD_UNUSED;
      it.gap = burst ? 0 : rand_gap();
      it.drain = ($urandom_range(59) == 0);
      pending.push_back(it);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || have_next || in_bus.valid) @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (TAPS + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("[stereo_fir_filter] OK");
    end else begin
      $display("[stereo_fir_filter] ERROR");
    end
    $finish;
  end

endmodule
